[sv/frame_send_pacer_top_assert.svh]
// assertion macros for the frame send pacer
`ifndef FRAME_SEND_PACER_TOP_ASSERT_SVH
`define FRAME_SEND_PACER_TOP_ASSERT_SVH

// same-cycle implication, checked at each rising edge outside reset
`define FSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame_send_pacer check failed");

// next-cycle implication
`define FSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame_send_pacer check failed");

`endif

[sv/fsp_pkg.sv]
package fsp_pkg;

    localparam int FLIGHT_DEPTH_DEF = 8;

    // channel widths
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 200;

    // function codes
    localparam logic [1:0] FUNC_HOLD   = 2'd0;
    localparam logic [1:0] FUNC_DONE   = 2'd1;
    localparam logic [1:0] FUNC_NOHOLD = 2'd2;

    // action codes
    localparam logic [2:0] ACT_STATUS    = 3'd0;
    localparam logic [2:0] ACT_SENT_CUR  = 3'd1;
    localparam logic [2:0] ACT_SENT_HELD = 3'd2;
    localparam logic [2:0] ACT_HELD      = 3'd3;
    localparam logic [2:0] ACT_DISCARD   = 3'd4;

    // register indexes
    localparam logic [1:0] REG_MAX_IN_FLIGHT = 2'd0;
    localparam logic [1:0] REG_HOLD_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_AGE_LIMIT     = 2'd2;
    localparam logic [1:0] REG_HEALTH_WINDOW = 2'd3;

    // health grades and thresholds
    localparam logic [1:0] HEALTH_OK        = 2'd0;
    localparam logic [1:0] HEALTH_CONGESTED = 2'd1;
    localparam logic [1:0] HEALTH_POOR      = 2'd2;
    localparam logic [31:0] POOR_STORE     = 32'd15;
    localparam logic [31:0] POOR_REPLACE   = 32'd8;
    localparam logic [31:0] TIMEOUT_LIMIT  = 32'd2;
    localparam logic [31:0] CONG_STORE     = 32'd6;
    localparam logic [31:0] CONG_REPLACE   = 32'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic tmo;
        logic health;
        logic retire;
        logic exec;
        logic emit;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic retire_more;
        logic out_free;
    } stat_t;

    // positive age strictly above limit
    function automatic logic older_than(logic [31:0] now, logic [31:0] then,
                                        logic [15:0] limit);
        logic [31:0] d;
        d = now - then;
        return !d[31] && (d > {16'b0, limit});
    endfunction

    function automatic logic [1:0] grade(logic [31:0] b, logic [31:0] r, logic [31:0] t);
        logic [1:0] g;
        if (b >= POOR_STORE && (r >= POOR_REPLACE || t >= TIMEOUT_LIMIT))
            g = HEALTH_POOR;
        else if (b >= CONG_STORE || r >= CONG_REPLACE || t >= TIMEOUT_LIMIT)
            g = HEALTH_CONGESTED;
        else
            g = HEALTH_OK;
        return g;
    endfunction

endpackage

[sv/fsp_ctrl.sv]
module fsp_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic [1:0]       s_tuser,
    output logic             s_tready,
    input  fsp_pkg::stat_t   stat,
    output fsp_pkg::cmd_t    cmd
);
    import fsp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_TMO    = 6'b000010,
        ST_HLTH   = 6'b000100,
        ST_RETIRE = 6'b001000,
        ST_EXEC   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // sequencing of one transaction
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tuser == FUNC_HOLD)
                        state_next = ST_TMO;
                    else if (s_tuser == FUNC_NOHOLD)
                        state_next = ST_RETIRE;
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_TMO:
            begin
                cmd.tmo    = 1'b1;
                state_next = ST_HLTH;
            end
            ST_HLTH:
            begin
                cmd.health = 1'b1;
                state_next = ST_RETIRE;
            end
            ST_RETIRE:
            begin
                if (stat.retire_more)
                    cmd.retire = 1'b1;
                else
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/fsp_datapath.sv]
module fsp_datapath #(
    parameter int FLIGHT_DEPTH = fsp_pkg::FLIGHT_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic [1:0]                      s_tuser,
    input  logic [fsp_pkg::IN_DATA_W-1:0]   s_tdata,
    input  fsp_pkg::cmd_t                   cmd,
    output fsp_pkg::stat_t                  stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2:0]                      m_tuser,
    output logic [fsp_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import fsp_pkg::*;

    localparam int PTR_W = (FLIGHT_DEPTH > 1) ? $clog2(FLIGHT_DEPTH) : 1;
    localparam int CNT_W = $clog2(FLIGHT_DEPTH + 1);

    // configuration
    logic [3:0]  max_reg;
    logic [15:0] hold_to_reg, age_reg, win_reg;

    // captured transaction
    logic [1:0]  func_reg;
    logic [31:0] now_reg, ftime_reg;
    logic [15:0] fid_reg;
    logic [23:0] fsize_reg;
    logic [3:0]  fkind_reg;

    // holding slot
    logic        hold_flag_reg;
    logic [31:0] hold_stamp_reg;
    logic [15:0] hold_ident_reg;
    logic [23:0] hold_bytes_reg;
    logic [3:0]  hold_type_reg;

    // in-flight fifo
    logic [31:0] flight_stamp_reg [FLIGHT_DEPTH];
    logic [15:0] flight_ident_reg [FLIGHT_DEPTH];
    logic [FLIGHT_DEPTH-1:0] flight_done_reg;
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;

    // counters and health
    logic [31:0] store_reg, replace_reg, timeout_reg, held_sent_reg;
    logic [31:0] win_begin_reg;
    logic        win_open_reg;
    logic [31:0] base_store_reg, base_replace_reg, base_timeout_reg;
    logic [1:0]  grade_reg;

    // result of the transaction
    logic [2:0]  res_action_reg;
    logic [15:0] res_id_reg;
    logic [31:0] res_time_reg;
    logic [23:0] res_size_reg;
    logic [3:0]  res_kind_reg;

    logic                  out_valid_reg;
    logic [2:0]            out_user_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // head check and busy test
    logic             head_hit, busy, full, hold_newer;
    logic [PTR_W-1:0] head_inc, tail;
    logic [FLIGHT_DEPTH-1:0] mark_hit;
    logic [31:0] win_d;
    logic [31:0] hold_diff;
    int          tsum;

    assign head_hit = (count_reg != '0) && (flight_done_reg[head_reg] ||
                      older_than(now_reg, flight_stamp_reg[head_reg], age_reg));
    assign full     = 32'(count_reg) >= FLIGHT_DEPTH;
    assign busy     = (max_reg != 4'd0) &&
                      (32'(count_reg) >= {28'b0, max_reg} || full);
    assign hold_diff  = hold_stamp_reg - ftime_reg;
    assign hold_newer = hold_flag_reg && !hold_diff[31];
    assign head_inc = (32'(head_reg) == FLIGHT_DEPTH - 1) ? '0 : head_reg + 1'b1;
    assign win_d    = now_reg - win_begin_reg;

    always_comb
    begin
        tsum = int'(head_reg) + int'(count_reg);
        if (tsum >= FLIGHT_DEPTH)
            tsum = tsum - FLIGHT_DEPTH;
        tail = PTR_W'(tsum);
    end

    // entries inside the live window whose id matches
    always_comb
    begin
        int off;
        for (int i = 0; i < FLIGHT_DEPTH; i++)
        begin
            off = i - int'(head_reg);
            if (off < 0)
                off = off + FLIGHT_DEPTH;
            mark_hit[i] = (off < int'(count_reg)) && (flight_ident_reg[i] == fid_reg);
        end
    end

    assign stat.retire_more = head_hit;
    assign stat.out_free    = !out_valid_reg || m_tready;

    // send decision
    logic        track_en;
    logic [31:0] track_stamp;
    logic [15:0] track_id;
    logic [2:0]  act;

    always_comb
    begin
        track_en    = 1'b0;
        track_stamp = ftime_reg;
        track_id    = fid_reg;
        act         = ACT_STATUS;
        if (func_reg == FUNC_HOLD)
        begin
            if (busy)
                act = ACT_HELD;
            else if (hold_newer)
            begin
                act         = ACT_SENT_HELD;
                track_en    = 1'b1;
                track_stamp = hold_stamp_reg;
                track_id    = hold_ident_reg;
            end
            else
            begin
                act      = ACT_SENT_CUR;
                track_en = 1'b1;
            end
        end
        else if (func_reg == FUNC_NOHOLD)
        begin
            if (busy)
                act = ACT_DISCARD;
            else
            begin
                act      = ACT_SENT_CUR;
                track_en = 1'b1;
            end
        end
    end

    // capture, result, fifo entries and payload (no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= s_tuser;
            now_reg   <= s_tdata[31:0];
            ftime_reg <= s_tdata[63:32];
            fid_reg   <= s_tdata[79:64];
            fsize_reg <= s_tdata[103:80];
            fkind_reg <= s_tdata[107:104];
        end
        if (cmd.exec)
        begin
            res_action_reg <= act;
            if (act == ACT_SENT_CUR || act == ACT_SENT_HELD)
            begin
                res_id_reg   <= (act == ACT_SENT_HELD) ? hold_ident_reg : fid_reg;
                res_time_reg <= (act == ACT_SENT_HELD) ? hold_stamp_reg : ftime_reg;
                res_size_reg <= (act == ACT_SENT_HELD) ? hold_bytes_reg : fsize_reg;
                res_kind_reg <= (act == ACT_SENT_HELD) ? hold_type_reg : fkind_reg;
            end
            else
            begin
                res_id_reg   <= '0;
                res_time_reg <= '0;
                res_size_reg <= '0;
                res_kind_reg <= '0;
            end
            if (track_en && max_reg != 4'd0)
            begin
                flight_stamp_reg[full ? head_reg : tail] <= track_stamp;
                flight_ident_reg[full ? head_reg : tail] <= track_id;
            end
        end
        if (cmd.emit)
        begin
            out_user_reg <= res_action_reg;
            out_data_reg <= {1'b0,
                             hold_flag_reg ? hold_bytes_reg : 24'd0,
                             hold_flag_reg,
                             timeout_reg, replace_reg, store_reg, grade_reg,
                             res_kind_reg, res_size_reg, res_time_reg, res_id_reg};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg          <= 4'd1;
            hold_to_reg      <= 16'd0;
            age_reg          <= 16'd500;
            win_reg          <= 16'd2000;
            hold_flag_reg    <= 1'b0;
            hold_stamp_reg   <= '0;
            hold_ident_reg   <= '0;
            hold_bytes_reg   <= '0;
            hold_type_reg    <= '0;
            flight_done_reg  <= '0;
            head_reg         <= '0;
            count_reg        <= '0;
            store_reg        <= '0;
            replace_reg      <= '0;
            timeout_reg      <= '0;
            held_sent_reg    <= '0;
            win_begin_reg    <= '0;
            win_open_reg     <= 1'b0;
            base_store_reg   <= '0;
            base_replace_reg <= '0;
            base_timeout_reg <= '0;
            grade_reg        <= HEALTH_OK;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_IN_FLIGHT: max_reg     <= cfg_data[3:0];
                    REG_HOLD_TIMEOUT:  hold_to_reg <= cfg_data;
                    REG_AGE_LIMIT:     age_reg     <= cfg_data;
                    REG_HEALTH_WINDOW: win_reg     <= cfg_data;
                    default: ;
                endcase
            end

            // held frame timeout
            if (cmd.tmo && hold_flag_reg && hold_to_reg != 16'd0 &&
                older_than(now_reg, hold_stamp_reg, hold_to_reg))
            begin
                timeout_reg   <= timeout_reg + 32'd1;
                hold_flag_reg <= 1'b0;
            end

            // health window
            if (cmd.health)
            begin
                if (!win_open_reg || (!win_d[31] && win_d >= {16'b0, win_reg}))
                begin
                    if (win_open_reg)
                        grade_reg <= grade(store_reg - base_store_reg,
                                           replace_reg - base_replace_reg,
                                           timeout_reg - base_timeout_reg);
                    win_open_reg     <= 1'b1;
                    win_begin_reg    <= now_reg;
                    base_store_reg   <= store_reg;
                    base_replace_reg <= replace_reg;
                    base_timeout_reg <= timeout_reg;
                end
            end

            // retire oldest entry
            if (cmd.retire && head_hit)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end

            // completion marking
            if (cmd.exec && func_reg == FUNC_DONE)
                flight_done_reg <= flight_done_reg | mark_hit;

            // send, hold or discard
            if (cmd.exec)
            begin
                if (act == ACT_HELD)
                begin
                    store_reg <= store_reg + 32'd1;
                    if (hold_flag_reg)
                        replace_reg <= replace_reg + 32'd1;
                    hold_flag_reg  <= 1'b1;
                    hold_stamp_reg <= ftime_reg;
                    hold_ident_reg <= fid_reg;
                    hold_bytes_reg <= fsize_reg;
                    hold_type_reg  <= fkind_reg;
                end
                else if (func_reg == FUNC_HOLD)
                begin
                    hold_flag_reg <= 1'b0;
                    if (act == ACT_SENT_HELD)
                        held_sent_reg <= held_sent_reg + 32'd1;
                end
                if (track_en && max_reg != 4'd0)
                begin
                    if (full)
                    begin
                        flight_done_reg[head_reg] <= 1'b0;
                        head_reg <= head_inc;
                    end
                    else
                    begin
                        flight_done_reg[tail] <= 1'b0;
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end

            // output register
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/frame_send_pacer_top.sv]
// frame send pacer
// input channel s_*: one transaction per frame event or completion; s_tuser
//   carries the function code, s_tdata the frame time and fields
// output channel m_*: exactly one result per input transaction, in order;
//   m_tuser carries the action, m_tdata the sent frame and status
// configuration: cfg_we writes cfg_data into the register at cfg_index
//   (0 max in flight, 1 hold timeout, 2 age limit, 3 health window)
// sequence: a completion or unused code goes from load straight to the
//   exec and emit steps; a frame without hold passes the retire loop
//   first, a frame with hold the timeout and health steps before that;
//   the retire loop of the controller retires in-flight entries one per cycle
// acceptance: one transaction in flight at a time; the next is taken once
//   the result has moved into the output register
// a stalled receiver holds the result in the output register; a further
//   result waits in the datapath result registers until that register frees
// reset clears the holding slot, the in-flight fifo, all counters, the
//   health window and sets the register defaults; no clearing pass needed
module frame_send_pacer_top #(
    parameter int FLIGHT_DEPTH = fsp_pkg::FLIGHT_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // func
    input  logic [1:0]                      s_tuser,
    // now_time, frame_time, frame_id, frame_size, frame_kind, zero fill
    input  logic [fsp_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // action
    output logic [2:0]                      m_tuser,
    // sent_id, sent_time, sent_size, sent_kind, health_level, store_total,
    // replace_total, timeout_total, hold_valid, hold_size, zero fill
    output logic [fsp_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import fsp_pkg::*;

    `include "frame_send_pacer_top_assert.svh"

    cmd_t  cmd;
    stat_t stat;

    fsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fsp_datapath #(
        .FLIGHT_DEPTH (FLIGHT_DEPTH)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // one transaction at a time
    `FSP_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    // no result appears right after an accept
    `FSP_ASSERT_NEXT(a_min_latency, s_tvalid && s_tready, !$rose(m_tvalid))
    // a held action leaves the slot occupied
    `FSP_ASSERT_NOW(a_held_slot, m_tvalid && m_tuser == ACT_HELD, m_tdata[174])
    // an empty slot reports zero size
    `FSP_ASSERT_NOW(a_empty_size, m_tvalid && !m_tdata[174], m_tdata[198:175] == 24'd0)

endmodule

[tb/sv/pacer_result_check.sv]
`timescale 1ns / 100ps

module pacer_result_check
    import fsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [1:0]             s_tuser,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [2:0]             m_tuser,
    input  logic [OUT_DATA_W-1:0]  m_tdata,
    output int                     fail_count,
    output int                     pending
);

    localparam int DEPTH = FLIGHT_DEPTH_DEF;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] sent_id;
        logic [31:0] sent_time;
        logic [23:0] sent_size;
        logic [3:0]  sent_kind;
        logic [1:0]  health;
        logic [31:0] stores;
        logic [31:0] replaces;
        logic [31:0] timeouts;
        logic        hold_valid;
        logic [23:0] hold_size;
    } pacer_result_t;

    // register copies
    logic [3:0]  max_flight;
    logic [15:0] hold_tmo;
    logic [15:0] age_limit;
    logic [15:0] win_len;

    // holding slot
    logic        slot_full;
    logic [31:0] slot_stamp;
    logic [15:0] slot_id;
    logic [23:0] slot_size;
    logic [3:0]  slot_kind;

    // in-flight fifo
    logic [31:0] fl_stamp [DEPTH];
    logic [15:0] fl_id [DEPTH];
    logic        fl_done [DEPTH];
    logic [2:0]  fl_head;
    int          fl_count;

    // counters and health window
    logic [31:0] store_cnt, replace_cnt, tmo_cnt;
    logic [31:0] win_begin;
    logic        win_open;
    logic [31:0] base_store, base_replace, base_tmo;
    logic [1:0]  grade_now;

    pacer_result_t expected_q[$];

    function automatic logic past_limit(logic [31:0] now, logic [31:0] then,
                                        logic [15:0] limit);
        logic [31:0] d;
        d = now - then;
        return !d[31] && (d > {16'b0, limit});
    endfunction

    task automatic take_baselines(input logic [31:0] now);
        win_begin    = now;
        base_store   = store_cnt;
        base_replace = replace_cnt;
        base_tmo     = tmo_cnt;
    endtask

    // open the window on first use, else grade the counter growth over a closed window
    task automatic refresh_health(input logic [31:0] now);
        logic [31:0] d, b, r, t;
        if (!win_open)
        begin
            win_open = 1'b1;
            take_baselines(now);
        end
        else
        begin
            d = now - win_begin;
            if (!d[31] && d >= {16'b0, win_len})
            begin
                b = store_cnt - base_store;
                r = replace_cnt - base_replace;
                t = tmo_cnt - base_tmo;
                if (b >= 15 && (r >= 8 || t >= 2))
                    grade_now = HEALTH_POOR;
                else if (b >= 6 || r >= 3 || t >= 2)
                    grade_now = HEALTH_CONGESTED;
                else
                    grade_now = HEALTH_OK;
                take_baselines(now);
            end
        end
    endtask

    // retire finished or aged entries, then compare against the limit
    task automatic link_check(input logic [31:0] now, output logic busy);
        int lim;
        while (fl_count > 0 &&
               (fl_done[fl_head] || past_limit(now, fl_stamp[fl_head], age_limit)))
        begin
            fl_head  = fl_head + 3'd1;
            fl_count = fl_count - 1;
        end
        lim  = (max_flight > DEPTH) ? DEPTH : int'(max_flight);
        busy = (lim != 0) && (fl_count >= lim);
    endtask

    task automatic log_send(input logic [31:0] stamp, input logic [15:0] id);
        logic [2:0] tail;
        if (max_flight != 0)
        begin
            if (fl_count >= DEPTH)
            begin
                fl_head  = fl_head + 3'd1;
                fl_count = fl_count - 1;
            end
            tail = fl_head + 3'(fl_count);
            fl_stamp[tail] = stamp;
            fl_id[tail]    = id;
            fl_done[tail]  = 1'b0;
            fl_count       = fl_count + 1;
        end
    endtask

    task automatic predict_pacing(input logic [1:0] fn, input logic [31:0] now,
                                  input logic [31:0] ft, input logic [15:0] id,
                                  input logic [23:0] sz, input logic [3:0] kd,
                                  output pacer_result_t r);
        logic        busy;
        logic [31:0] d;
        logic [2:0]  idx;
        r = '0;
        case (fn)
            FUNC_HOLD:
            begin
                if (slot_full && hold_tmo != 0 && past_limit(now, slot_stamp, hold_tmo))
                begin
                    tmo_cnt   = tmo_cnt + 1;
                    slot_full = 1'b0;
                end
                refresh_health(now);
                link_check(now, busy);
                d = slot_stamp - ft;
                if (busy)
                begin
                    store_cnt = store_cnt + 1;
                    if (slot_full)
                        replace_cnt = replace_cnt + 1;
                    slot_full  = 1'b1;
                    slot_stamp = ft;
                    slot_id    = id;
                    slot_size  = sz;
                    slot_kind  = kd;
                    r.action   = ACT_HELD;
                end
                else if (slot_full && !d[31])
                begin
                    slot_full   = 1'b0;
                    r.action    = ACT_SENT_HELD;
                    r.sent_id   = slot_id;
                    r.sent_time = slot_stamp;
                    r.sent_size = slot_size;
                    r.sent_kind = slot_kind;
                    log_send(slot_stamp, slot_id);
                end
                else
                begin
                    slot_full   = 1'b0;
                    r.action    = ACT_SENT_CUR;
                    r.sent_id   = id;
                    r.sent_time = ft;
                    r.sent_size = sz;
                    r.sent_kind = kd;
                    log_send(ft, id);
                end
            end
            FUNC_DONE:
            begin
                for (int k = 0; k < fl_count; k++)
                begin
                    idx = fl_head + 3'(k);
                    if (fl_id[idx] == id)
                        fl_done[idx] = 1'b1;
                end
                r.action = ACT_STATUS;
            end
            FUNC_NOHOLD:
            begin
                link_check(now, busy);
                if (busy)
                    r.action = ACT_DISCARD;
                else
                begin
                    r.action    = ACT_SENT_CUR;
                    r.sent_id   = id;
                    r.sent_time = ft;
                    r.sent_size = sz;
                    r.sent_kind = kd;
                    log_send(ft, id);
                end
            end
            default:
                r.action = ACT_STATUS;
        endcase
        r.health     = grade_now;
        r.stores     = store_cnt;
        r.replaces   = replace_cnt;
        r.timeouts   = tmo_cnt;
        r.hold_valid = slot_full;
        r.hold_size  = slot_full ? slot_size : 24'd0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        fail_count = fail_count + 1;
    endtask

    // field by field compare of one output transaction
    task automatic compare_result(input pacer_result_t e);
        if (m_tuser != e.action)
            report_mismatch("action", 32'(m_tuser), 32'(e.action));
        if (m_tdata[15:0] != e.sent_id)
            report_mismatch("sent_id", 32'(m_tdata[15:0]), 32'(e.sent_id));
        if (m_tdata[47:16] != e.sent_time)
            report_mismatch("sent_time", m_tdata[47:16], e.sent_time);
        if (m_tdata[71:48] != e.sent_size)
            report_mismatch("sent_size", 32'(m_tdata[71:48]), 32'(e.sent_size));
        if (m_tdata[75:72] != e.sent_kind)
            report_mismatch("sent_kind", 32'(m_tdata[75:72]), 32'(e.sent_kind));
        if (m_tdata[77:76] != e.health)
            report_mismatch("health_level", 32'(m_tdata[77:76]), 32'(e.health));
        if (m_tdata[109:78] != e.stores)
            report_mismatch("store_total", m_tdata[109:78], e.stores);
        if (m_tdata[141:110] != e.replaces)
            report_mismatch("replace_total", m_tdata[141:110], e.replaces);
        if (m_tdata[173:142] != e.timeouts)
            report_mismatch("timeout_total", m_tdata[173:142], e.timeouts);
        if (m_tdata[174] != e.hold_valid)
            report_mismatch("hold_valid", 32'(m_tdata[174]), 32'(e.hold_valid));
        if (m_tdata[198:175] != e.hold_size)
            report_mismatch("hold_size", 32'(m_tdata[198:175]), 32'(e.hold_size));
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        pacer_result_t r;
        if (!rst_n)
        begin
            max_flight  = 4'd1;
            hold_tmo    = 16'd0;
            age_limit   = 16'd500;
            win_len     = 16'd2000;
            slot_full   = 1'b0;
            slot_stamp  = '0;
            slot_id     = '0;
            slot_size   = '0;
            slot_kind   = '0;
            for (int k = 0; k < DEPTH; k++)
                fl_done[k] = 1'b0;
            fl_head     = '0;
            fl_count    = 0;
            store_cnt   = '0;
            replace_cnt = '0;
            tmo_cnt     = '0;
            win_begin   = '0;
            win_open    = 1'b0;
            base_store  = '0;
            base_replace = '0;
            base_tmo    = '0;
            grade_now   = HEALTH_OK;
            expected_q.delete();
            pending     = 0;
            fail_count  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_IN_FLIGHT: max_flight = cfg_data[3:0];
                    REG_HOLD_TIMEOUT:  hold_tmo   = cfg_data;
                    REG_AGE_LIMIT:     age_limit  = cfg_data;
                    REG_HEALTH_WINDOW: win_len    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_pacing(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[79:64],
                               s_tdata[103:80], s_tdata[107:104], r);
                expected_q = {expected_q, r};
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected output transaction", $realtime);
                    fail_count = fail_count + 1;
                end
                else
                    compare_result(expected_q.pop_front());
            end
            pending = expected_q.size();
        end
    end

endmodule

[tb/sv/frame_send_pacer_top_test.sv]
`timescale 1ns / 100ps

module frame_send_pacer_top_test;
    import fsp_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 285;

    // function code with no meaning, answered by the block with a status result
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [1:0]             cfg_index = '0;
    logic [15:0]            cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [1:0]             s_tuser = '0;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [2:0]             m_tuser;
    logic [OUT_DATA_W-1:0]  m_tdata;

    int          fail_count;
    int          pending;
    int          send_idle = 23;
    int          recv_idle = 46;
    int          quiet_cycles = 0;
    logic [31:0] now_ms = '0;

    always #5 clk = ~clk;

    frame_send_pacer_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    pacer_result_check u_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver backpressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle);

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // one input transaction, with random gaps ahead of it
    task automatic send_event(input logic [1:0] fn, input logic [31:0] now,
                              input logic [31:0] ft, input logic [15:0] id,
                              input logic [23:0] sz, input logic [3:0] kd);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {4'b0, kd, sz, id, ft, now};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (30) @(negedge clk);
    endtask

    // mix of frames, completions and the spare code with random content
    task automatic random_event();
        logic [1:0]  fn;
        logic [31:0] ft;
        logic [15:0] id;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            fn = FUNC_HOLD;
        else if (pick < 70)
            fn = FUNC_DONE;
        else if (pick < 95)
            fn = FUNC_NOHOLD;
        else
            fn = FUNC_SPARE;
        if ($urandom_range(0, 99) < 2)
            now_ms = $urandom;
        else
            now_ms = now_ms + $urandom_range(0, 30);
        if ($urandom_range(0, 99) < 80)
            ft = now_ms - $urandom_range(0, 60) + $urandom_range(0, 8);
        else
            ft = $urandom;
        if ($urandom_range(0, 99) < 70)
            id = 16'($urandom_range(0, 15));
        else
            id = 16'($urandom);
        send_event(fn, now_ms, ft, id, 24'($urandom), 4'($urandom));
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: send, hold, replace, complete, held send, discard
        send_event(FUNC_HOLD,   32'd0, 32'd0, 16'h0000, 24'd0, 4'd0);
        send_event(FUNC_HOLD,   32'd1, 32'd1, 16'hFFFF, 24'hFFFFFF, 4'd15);
        send_event(FUNC_HOLD,   32'd2, 32'd5, 16'd7, 24'd100, 4'd3);
        send_event(FUNC_NOHOLD, 32'd3, 32'd3, 16'd8, 24'd1, 4'd1);
        send_event(FUNC_DONE,   32'd4, 32'd0, 16'h0000, 24'd0, 4'd0);
        send_event(FUNC_HOLD,   32'd5, 32'd2, 16'd9, 24'd5, 4'd2);
        send_event(FUNC_SPARE,  32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, 4'd15);
        send_event(FUNC_DONE,   32'd6, 32'd0, 16'd7, 24'd0, 4'd0);
        send_event(FUNC_HOLD,   32'd7, 32'd7, 16'd10, 24'd6, 4'd4);
        send_event(FUNC_HOLD,   32'd8, 32'd9, 16'd11, 24'd7, 4'd5);
        send_event(FUNC_HOLD,   32'd9, 32'd1, 16'd12, 24'd8, 4'd6);
        // entry ages out past the limit, held frame newer than offered
        send_event(FUNC_HOLD,   32'd600, 32'd0, 16'd13, 24'd9, 4'd7);
        send_event(FUNC_NOHOLD, 32'd601, 32'd601, 16'd14, 24'd10, 4'd8);
        // window closes and grades, future timestamps
        send_event(FUNC_HOLD,   32'd2600, 32'hFFFFFFF0, 16'd15, 24'd11, 4'd9);
        send_event(FUNC_HOLD,   32'd2601, 32'h7FFFFFFF, 16'd16, 24'd12, 4'd10);
        drain_and_settle();
        // hold timeout
        write_reg(REG_HOLD_TIMEOUT, 16'd5);
        send_event(FUNC_HOLD,   32'd2602, 32'd2602, 16'd17, 24'd13, 4'd11);
        send_event(FUNC_HOLD,   32'd2620, 32'd2620, 16'd18, 24'd14, 4'd12);
        send_event(FUNC_HOLD,   32'd2640, 32'd2640, 16'd19, 24'd15, 4'd13);
        drain_and_settle();
        now_ms = 32'd3000;

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle = 23;
                    recv_idle = 46;
                end
                1:
                begin
                    send_idle = 46;
                    recv_idle = 23;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (ph)
                0:
                begin
                    write_reg(REG_MAX_IN_FLIGHT, 16'd2);
                    write_reg(REG_HOLD_TIMEOUT, 16'd40);
                    write_reg(REG_AGE_LIMIT, 16'd100);
                    write_reg(REG_HEALTH_WINDOW, 16'd150);
                end
                1:
                begin
                    write_reg(REG_MAX_IN_FLIGHT, 16'd15);
                    write_reg(REG_HOLD_TIMEOUT, 16'd65535);
                    write_reg(REG_AGE_LIMIT, 16'd65535);
                    write_reg(REG_HEALTH_WINDOW, 16'd1);
                    now_ms = 32'hFFFFF000;
                end
                2:
                begin
                    write_reg(REG_MAX_IN_FLIGHT, 16'd0);
                    write_reg(REG_HOLD_TIMEOUT, 16'd0);
                    write_reg(REG_AGE_LIMIT, 16'd1);
                    write_reg(REG_HEALTH_WINDOW, 16'd65535);
                end
                3:
                begin
                    write_reg(REG_MAX_IN_FLIGHT, 16'd8);
                    write_reg(REG_HOLD_TIMEOUT, 16'd20);
                    write_reg(REG_AGE_LIMIT, 16'd0);
                    write_reg(REG_HEALTH_WINDOW, 16'd0);
                end
                4:
                begin
                    write_reg(REG_MAX_IN_FLIGHT, 16'd1);
                    write_reg(REG_HOLD_TIMEOUT, 16'd10);
                    write_reg(REG_AGE_LIMIT, 16'd300);
                    write_reg(REG_HEALTH_WINDOW, 16'd80);
                end
                default:
                begin
                    write_reg(REG_MAX_IN_FLIGHT, 16'd4);
                    write_reg(REG_HOLD_TIMEOUT, 16'd1);
                    write_reg(REG_AGE_LIMIT, 16'd50);
                    write_reg(REG_HEALTH_WINDOW, 16'd300);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_event();
            drain_and_settle();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
